[hw/rtl/spmh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmh_pkg
// Shared constants and types for the shelf partition block.
// ----------------------------------------------------------------------------
package spmh_pkg;

   localparam int MAX_BOOKS     = 1024;
   localparam int DIM_BITS      = 10;
   localparam int COUNT_BITS    = $clog2(MAX_BOOKS + 1);
   localparam int TOTAL_BITS    = DIM_BITS + $clog2(MAX_BOOKS) + 1;
   localparam int USED_BITS     = DIM_BITS + 1;
   localparam int OUT_BITS      = 20;
   localparam int IN_DATA_BITS  = ((2 * DIM_BITS + 7) / 8) * 8;
   localparam int OUT_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;
   localparam logic [DIM_BITS-1:0] SHELF_RESET = DIM_BITS'(1023);

   // one stored book; prev_best is the best total of the books before it
   typedef struct packed {
      logic [DIM_BITS-1:0]   width;
      logic [DIM_BITS-1:0]   height;
      logic [TOTAL_BITS-1:0] prev_best;
   } book_type;

   // walk state travelling down the chain
   typedef struct packed {
      logic                  valid;
      logic                  fresh;
      logic                  done;
      logic [USED_BITS-1:0]  used;
      logic [DIM_BITS-1:0]   tallest;
      logic [TOTAL_BITS-1:0] best;
   } token_type;

endpackage

[hw/rtl/spmh_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmh_cell
// One chain cell: holds one book and advances the walk token by one book.
// ----------------------------------------------------------------------------
module spmh_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift,
   input  logic                          cell_on,
   input  logic [spmh_pkg::DIM_BITS-1:0] shelf_span,
   input  spmh_pkg::book_type            prev_book,
   input  spmh_pkg::token_type           prev_tok,
   output spmh_pkg::book_type            book_out,
   output spmh_pkg::token_type           tok_out
);

   spmh_pkg::book_type  book_ff, book_in;
   spmh_pkg::token_type tok_ff, tok_in;

   always_comb begin
      book_in = shift ? prev_book : book_ff;
   end

   always_comb begin
      logic [spmh_pkg::USED_BITS-1:0]  used_sum;
      logic [spmh_pkg::USED_BITS-1:0]  own_width;
      logic [spmh_pkg::DIM_BITS-1:0]   tall;
      logic [spmh_pkg::TOTAL_BITS-1:0] cand;
      own_width = {1'b0, book_ff.width};
      used_sum  = prev_tok.used + own_width;
      tall      = (book_ff.height > prev_tok.tallest) ? book_ff.height : prev_tok.tallest;
      cand      = book_ff.prev_best + spmh_pkg::TOTAL_BITS'(tall);
      tok_in    = prev_tok;
      if (prev_tok.valid && !prev_tok.done) begin
         if (prev_tok.fresh) begin
            // newest book: a shelf of its own is the starting candidate
            tok_in.fresh   = 1'b0;
            tok_in.used    = own_width;
            tok_in.tallest = book_ff.height;
            tok_in.best    = book_ff.prev_best + spmh_pkg::TOTAL_BITS'(book_ff.height);
            tok_in.done    = (own_width > {1'b0, shelf_span});
         end else if (!cell_on || (used_sum > {1'b0, shelf_span})) begin
            tok_in.done = 1'b1;
         end else begin
            tok_in.used    = used_sum;
            tok_in.tallest = tall;
            if (cand < prev_tok.best) begin
               tok_in.best = cand;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      book_ff <= book_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign book_out = book_ff;
   assign tok_out  = tok_ff;

endmodule

[hw/rtl/shelf_partition_min_height.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shelf_partition_min_height
// Minimum total shelf height over an ordered stream of books, computed by a
// shifting chain of book cells with a walk token passing one cell per cycle.
// ----------------------------------------------------------------------------
// A stored book's result is registered once the walk token has crossed the full
// chain; a dropped book's result is registered directly, with the overflow flag.
// Only one book is in flight: no new book is taken until the token of the last
// one leaves the end of the cell chain and the result slot is free.
// Reset: book count cleared, shelf width back to 1023, no result pending.
// ----------------------------------------------------------------------------
module shelf_partition_min_height (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [spmh_pkg::DIM_BITS-1:0]      csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // book_width, book_height, zero pad
   input  logic [spmh_pkg::IN_DATA_BITS-1:0]  req_tdata,
   // new_set
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // total_height, zero pad
   output logic [spmh_pkg::OUT_DATA_BITS-1:0] rsp_tdata,
   // overflow
   output logic                               rsp_tuser
);

   localparam int N = spmh_pkg::MAX_BOOKS;
   localparam int D = spmh_pkg::DIM_BITS;

   logic [D-1:0]                      shelf_ff, shelf_in;
   logic [spmh_pkg::COUNT_BITS-1:0]   count_ff, count_in;
   logic                              busy_ff, busy_in;
   logic [spmh_pkg::TOTAL_BITS-1:0]   last_best_ff, last_best_in;
   spmh_pkg::token_type               inject_ff, inject_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [spmh_pkg::OUT_BITS-1:0]     rsp_total_ff, rsp_total_in;
   logic                              rsp_ovf_ff, rsp_ovf_in;

   logic                              accept, full, shift;
   logic [spmh_pkg::COUNT_BITS-1:0]   base_count;
   logic [spmh_pkg::TOTAL_BITS-1:0]   base_best;
   logic [D-1:0]                      in_width, in_height;
   spmh_pkg::book_type                new_book;
   spmh_pkg::token_type               finish_tok;

   spmh_pkg::book_type  chain_book [N];
   spmh_pkg::token_type chain_tok  [N];
   logic [N-1:0]        cell_on;

   assign in_width   = req_tdata[D-1:0];
   assign in_height  = req_tdata[2*D-1:D];
   assign req_tready = !busy_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign base_count = req_tuser ? '0 : count_ff;
   assign base_best  = req_tuser ? '0 : last_best_ff;
   assign full       = (base_count >= spmh_pkg::COUNT_BITS'(N));
   assign shift      = accept && !full;
   assign finish_tok = chain_tok[N-1];

   always_comb begin
      new_book.width     = in_width;
      new_book.height    = in_height;
      new_book.prev_best = base_best;
   end

   always_comb begin
      shelf_in     = csr_we ? csr_wdata : shelf_ff;
      count_in     = count_ff;
      busy_in      = busy_ff;
      last_best_in = last_best_ff;
      inject_in    = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_total_in = rsp_total_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (accept) begin
         if (full) begin
            rsp_valid_in = 1'b1;
            rsp_total_in = last_best_ff[spmh_pkg::OUT_BITS-1:0];
            rsp_ovf_in   = 1'b1;
         end else begin
            count_in        = base_count + 1'b1;
            busy_in         = 1'b1;
            last_best_in    = base_best;
            inject_in.valid = 1'b1;
            inject_in.fresh = 1'b1;
         end
      end
      if (finish_tok.valid) begin
         busy_in      = 1'b0;
         last_best_in = finish_tok.best;
         rsp_valid_in = 1'b1;
         rsp_total_in = finish_tok.best[spmh_pkg::OUT_BITS-1:0];
         rsp_ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_total_ff <= rsp_total_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      if (reset) begin
         shelf_ff     <= spmh_pkg::SHELF_RESET;
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         last_best_ff <= '0;
         inject_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         shelf_ff     <= shelf_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         last_best_ff <= last_best_in;
         inject_ff    <= inject_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // cell k holds book count-1-k; token enters at cell 0 in the cycle after the shift
   for (genvar k = 0; k < N; k++) begin : g_cell
      spmh_pkg::book_type  prev_book;
      spmh_pkg::token_type prev_tok;
      assign cell_on[k] = (spmh_pkg::COUNT_BITS'(k) < count_ff);
      if (k == 0) begin : g_head
         assign prev_book = new_book;
         assign prev_tok  = inject_ff;
      end else begin : g_body
         assign prev_book = chain_book[k-1];
         assign prev_tok  = chain_tok[k-1];
      end
      spmh_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift       (shift),
         .cell_on     (cell_on[k]),
         .shelf_span  (shelf_ff),
         .prev_book   (prev_book),
         .prev_tok    (prev_tok),
         .book_out    (chain_book[k]),
         .tok_out     (chain_tok[k])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = spmh_pkg::OUT_DATA_BITS'(rsp_total_ff);
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the shelf partition block. Books are streamed in with random gaps
// and random result back-pressure. A scoreboard class runs its own prefix
// minimum-height calculation and compares every result in arrival order.
// Several shelf widths are covered.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct {
      logic [19:0] total;
      logic        dropped;
   } shelf_result_type;

   class shelf_scoreboard;
      logic [spmh_pkg::DIM_BITS-1:0] widths[spmh_pkg::MAX_BOOKS];
      logic [spmh_pkg::DIM_BITS-1:0] heights[spmh_pkg::MAX_BOOKS];
      logic [20:0]                   prefix_best[spmh_pkg::MAX_BOOKS];
      int                            stored;
      logic [spmh_pkg::DIM_BITS-1:0] shelf;
      shelf_result_type              due[$];
      int                            errors;

      function new();
         stored = 0;
         shelf  = spmh_pkg::SHELF_RESET;
         errors = 0;
      endfunction

      // Work out the answer for one accepted book and queue it.
      function void note_book(bit fresh, logic [spmh_pkg::DIM_BITS-1:0] w,
                              logic [spmh_pkg::DIM_BITS-1:0] h);
         shelf_result_type r;
         int               used;
         int               tallest;
         int               j;
         logic [20:0]      best;
         logic [20:0]      cand;
         if (fresh)
            stored = 0;
         if (stored >= spmh_pkg::MAX_BOOKS) begin
            r.total   = prefix_best[spmh_pkg::MAX_BOOKS-1][19:0];
            r.dropped = 1'b1;
            due.push_back(r);
            return;
         end
         widths[stored]  = w;
         heights[stored] = h;
         best = (stored > 0 ? prefix_best[stored-1] : 21'd0) + h;
         if (w <= shelf) begin
            used    = w;
            tallest = h;
            j       = stored;
            while (j > 0) begin
               j--;
               used += widths[j];
               if (used > shelf)
                  break;
               if (heights[j] > tallest)
                  tallest = heights[j];
               cand = (j > 0 ? prefix_best[j-1] : 21'd0) + 21'(tallest);
               if (cand < best)
                  best = cand;
            end
         end
         prefix_best[stored] = best;
         stored++;
         r.total   = best[19:0];
         r.dropped = 1'b0;
         due.push_back(r);
      endfunction

      function void check_result(logic [19:0] total, logic dropped);
         shelf_result_type e;
         if (due.size() == 0) begin
            $display("%0t: unexpected result total=%0d overflow=%0b",
                     $time, total, dropped);
            errors++;
            return;
         end
         e = due.pop_front();
         if (total !== e.total) begin
            $display("%0t: total_height expected %0d actual %0d",
                     $time, e.total, total);
            errors++;
         end
         if (dropped !== e.dropped) begin
            $display("%0t: overflow expected %0b actual %0b",
                     $time, e.dropped, dropped);
            errors++;
         end
      endfunction

      function int pending();
         return due.size();
      endfunction
   endclass

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_we = 1'b0;
   logic [spmh_pkg::DIM_BITS-1:0]      csr_wdata = '0;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [spmh_pkg::IN_DATA_BITS-1:0]  req_tdata = '0;
   logic                               req_tuser = 1'b0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [spmh_pkg::OUT_DATA_BITS-1:0] rsp_tdata;
   logic                               rsp_tuser;

   shelf_scoreboard books = new();
   bit              no_gaps = 1'b0;
   bit              long_hold = 1'b0;

   always #1 clock = ~clock;

   shelf_partition_min_height dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   task automatic send_book(bit fresh, logic [spmh_pkg::DIM_BITS-1:0] w,
                            logic [spmh_pkg::DIM_BITS-1:0] h);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(spmh_pkg::IN_DATA_BITS - 2 * spmh_pkg::DIM_BITS){1'b0}}, h, w};
      req_tuser  <= fresh;
      do @(posedge clock); while (!req_tready);
      books.note_book(fresh, w, h);
      @(negedge clock);
   endtask

   // Sender pauses until every queued result is back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (books.pending() > 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic set_shelf(logic [spmh_pkg::DIM_BITS-1:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
      books.shelf = v;
   endtask

   // Book widths skewed small so that several books share a shelf.
   task automatic random_sets(int count);
      int                            k;
      int                            pick;
      logic [spmh_pkg::DIM_BITS-1:0] w;
      logic [spmh_pkg::DIM_BITS-1:0] h;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(0, 9);
         if (pick < 7)
            w = spmh_pkg::DIM_BITS'($urandom_range(0, books.shelf / 4 + 1));
         else if (pick < 9)
            w = spmh_pkg::DIM_BITS'($urandom_range(0, books.shelf));
         else
            w = spmh_pkg::DIM_BITS'($urandom_range(0, 1023));
         h = spmh_pkg::DIM_BITS'($urandom_range(0, 1023));
         send_book(k == 0 || $urandom_range(0, 11) == 0, w, h);
      end
   endtask

   // result side
   initial begin
      int gap;
      @(negedge clock);
      wait (!reset);
      forever begin
         gap = no_gaps ? 0 : $urandom_range(0, 19);
         if (long_hold) begin
            gap = 3000;
            long_hold = 1'b0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         books.check_result(rsp_tdata[19:0], rsp_tuser);
         @(negedge clock);
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, default width 1023
      send_book(1, 0, 0);
      send_book(0, 1023, 1023);
      send_book(0, 0, 5);
      send_book(0, 1023, 0);
      send_book(0, 512, 700);
      send_book(0, 511, 3);
      send_book(0, 1, 1023);
      send_book(1, 341, 682);
      send_book(0, 682, 341);
      // zero width: only zero-width books share a shelf
      set_shelf(0);
      send_book(1, 0, 7);
      send_book(0, 0, 9);
      send_book(0, 1, 4);
      send_book(0, 0, 2);
      // books wider than the shelf
      set_shelf(1);
      send_book(1, 1, 6);
      send_book(0, 1023, 8);
      send_book(0, 1, 3);
      send_book(0, 0, 10);
      send_book(0, 1, 1);

      set_shelf(1023);
      random_sets(140);
      set_shelf(37);
      long_hold = 1'b1;
      random_sets(140);
      set_shelf(1);
      no_gaps = 1'b1;
      random_sets(140);
      no_gaps = 1'b0;
      set_shelf(spmh_pkg::DIM_BITS'($urandom_range(2, 1022)));
      random_sets(140);

      drain();
      repeat (20) @(negedge clock);
      if (books.errors == 0 && books.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #10000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
